// ===== sv/ghh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghh_pkg
// Shared types and constants of the golden-ratio hue to RGB color generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ghh_pkg;

  // Fraction bits of hue, f, saturation, value and the levels
  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CH_W      = 8;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * LVL_W;
  localparam int H6_W      = FRAC_BITS + 3;
  localparam int SEC_W     = 3;

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [LVL_W-1:0]     level_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [SEC_W-1:0]     sector_t;
  typedef logic [CH_W-1:0]      chan_t;

  localparam level_t ONE_LEVEL = level_t'(1) << FRAC_BITS;

  // Golden-ratio conjugate in 0.32 format, rounded to FRAC_BITS bits
  localparam logic [63:0] GOLD_Q32 = 64'd2654435769;
  localparam frac_t GOLD_STEP =
      frac_t'((GOLD_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = CFG_IDX_W'(1);

  // Hue sectors
  localparam sector_t SEC_RED_YEL = 3'd0;
  localparam sector_t SEC_YEL_GRN = 3'd1;
  localparam sector_t SEC_GRN_CYA = 3'd2;
  localparam sector_t SEC_CYA_BLU = 3'd3;
  localparam sector_t SEC_BLU_MAG = 3'd4;
  localparam sector_t SEC_MAG_RED = 3'd5;

  typedef struct packed {
    sector_t sector;
    frac_t   frac;
  } hue_t;

  typedef struct packed {
    sector_t sector;
    level_t  p;
    level_t  q;
    level_t  t;
  } lvl_set_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

endpackage

`default_nettype wire

// ===== sv/ghh_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghh_cfg_regs
// Saturation and value registers; writes above one saturate to one.
// ----------------------------------------------------------------------------
`default_nettype none

module ghh_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ghh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ghh_pkg::CFG_W-1:0]     cfg_wdata_i,
  output ghh_pkg::level_t                    sat_o,
  output ghh_pkg::level_t                    bright_o
);

  ghh_pkg::level_t sat_q, sat_d;
  ghh_pkg::level_t bright_q, bright_d;
  ghh_pkg::level_t wval;

  always_comb begin
    if (32'(cfg_wdata_i) > 32'(ghh_pkg::ONE_LEVEL)) begin
      wval = ghh_pkg::ONE_LEVEL;
    end else begin
      wval = ghh_pkg::level_t'(cfg_wdata_i);
    end
    sat_d    = sat_q;
    bright_d = bright_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == ghh_pkg::REG_SAT) begin
        sat_d = wval;
      end else if (cfg_idx_i == ghh_pkg::REG_BRIGHT) begin
        bright_d = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q    <= ghh_pkg::ONE_LEVEL;
      bright_q <= ghh_pkg::ONE_LEVEL;
    end else begin
      sat_q    <= sat_d;
      bright_q <= bright_d;
    end
  end

  assign sat_o    = sat_q;
  assign bright_o = bright_q;

endmodule

`default_nettype wire

// ===== sv/ghh_sector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghh_sector
// Stage 1: add the golden step modulo one, split hue*6 into sector and f.
// ----------------------------------------------------------------------------
`default_nettype none

module ghh_sector (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           stall_o,
  input  wire logic [ghh_pkg::HUE_W-1:0] hue_i,
  output logic                           valid_o,
  input  wire logic                      stall_i,
  output ghh_pkg::hue_t                  data_o
);

  logic valid_q, valid_d;
  logic en;
  ghh_pkg::hue_t data_q, data_d;
  ghh_pkg::frac_t hue;
  logic [ghh_pkg::H6_W-1:0] h6;

  assign en = !valid_q || !stall_i;

  always_comb begin
    // bits above the fraction drop out here, the sum wraps modulo one
    hue = ghh_pkg::frac_t'(hue_i) + ghh_pkg::GOLD_STEP;
    h6  = (ghh_pkg::H6_W'(hue) << 2) + (ghh_pkg::H6_W'(hue) << 1);
    data_d.sector = h6[ghh_pkg::H6_W-1:ghh_pkg::FRAC_BITS];
    data_d.frac   = h6[ghh_pkg::FRAC_BITS-1:0];
    valid_d = en ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign stall_o = !en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== sv/ghh_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghh_level
// Stages 2 and 3: scale f and 1-f by saturation and form p, then form q and t.
// ----------------------------------------------------------------------------
`default_nettype none

module ghh_level (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ghh_pkg::level_t sat_i,
  input  wire ghh_pkg::level_t bright_i,
  input  wire logic      valid_i,
  output logic           stall_o,
  input  wire ghh_pkg::hue_t  data_i,
  output logic           valid_o,
  input  wire logic      stall_i,
  output ghh_pkg::lvl_set_t data_o
);

  // stage 2 holds sector, f*S, (1-f)*S and p
  logic v2_q, v2_d;
  logic v3_q, v3_d;
  logic en2, en3;
  ghh_pkg::sector_t sec2_q;
  ghh_pkg::level_t  fs2_q, gs2_q, p2_q;
  ghh_pkg::level_t  fs2_d, gs2_d, p2_d;
  ghh_pkg::prod_t   prod_fs, prod_gs, prod_p, prod_q, prod_t;
  ghh_pkg::lvl_set_t data3_q, data3_d;

  assign en3 = !v3_q || !stall_i;
  assign en2 = !v2_q || en3;

  always_comb begin
    prod_fs = ghh_pkg::prod_t'(data_i.frac) * ghh_pkg::prod_t'(sat_i);
    prod_gs = ghh_pkg::prod_t'(ghh_pkg::ONE_LEVEL - ghh_pkg::level_t'(data_i.frac))
            * ghh_pkg::prod_t'(sat_i);
    prod_p  = ghh_pkg::prod_t'(bright_i)
            * ghh_pkg::prod_t'(ghh_pkg::ONE_LEVEL - sat_i);
    fs2_d = ghh_pkg::level_t'(prod_fs >> ghh_pkg::FRAC_BITS);
    gs2_d = ghh_pkg::level_t'(prod_gs >> ghh_pkg::FRAC_BITS);
    p2_d  = ghh_pkg::level_t'(prod_p >> ghh_pkg::FRAC_BITS);
    v2_d  = en2 ? valid_i : v2_q;

    prod_q = ghh_pkg::prod_t'(bright_i) * ghh_pkg::prod_t'(ghh_pkg::ONE_LEVEL - fs2_q);
    prod_t = ghh_pkg::prod_t'(bright_i) * ghh_pkg::prod_t'(ghh_pkg::ONE_LEVEL - gs2_q);
    data3_d.sector = sec2_q;
    data3_d.p      = p2_q;
    data3_d.q      = ghh_pkg::level_t'(prod_q >> ghh_pkg::FRAC_BITS);
    data3_d.t      = ghh_pkg::level_t'(prod_t >> ghh_pkg::FRAC_BITS);
    v3_d = en3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sec2_q <= data_i.sector;
      fs2_q  <= fs2_d;
      gs2_q  <= gs2_d;
      p2_q   <= p2_d;
    end
    if (en3) begin
      data3_q <= data3_d;
    end
  end

  assign stall_o = !en2;
  assign valid_o = v3_q;
  assign data_o  = data3_q;

endmodule

`default_nettype wire

// ===== sv/ghh_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghh_color
// Stage 4: pick the level per channel by sector and scale it to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ghh_color (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ghh_pkg::level_t  bright_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire ghh_pkg::lvl_set_t data_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output ghh_pkg::rgb_t    data_o
);

  localparam int CW_W = ghh_pkg::LVL_W + 8;

  logic valid_q, valid_d;
  logic en;
  ghh_pkg::level_t r_lvl, g_lvl, b_lvl;
  ghh_pkg::rgb_t data_q, data_d;

  function automatic ghh_pkg::chan_t to_chan(input ghh_pkg::level_t lvl);
    logic [CW_W-1:0] x;
    x = (CW_W'(lvl) << 8) - CW_W'(lvl);
    return x[ghh_pkg::FRAC_BITS+7:ghh_pkg::FRAC_BITS];
  endfunction

  assign en = !valid_q || !stall_i;

  always_comb begin
    unique case (data_i.sector)
      ghh_pkg::SEC_RED_YEL: begin
        r_lvl = bright_i;   g_lvl = data_i.t;   b_lvl = data_i.p;
      end
      ghh_pkg::SEC_YEL_GRN: begin
        r_lvl = data_i.q;   g_lvl = bright_i;   b_lvl = data_i.p;
      end
      ghh_pkg::SEC_GRN_CYA: begin
        r_lvl = data_i.p;   g_lvl = bright_i;   b_lvl = data_i.t;
      end
      ghh_pkg::SEC_CYA_BLU: begin
        r_lvl = data_i.p;   g_lvl = data_i.q;   b_lvl = bright_i;
      end
      ghh_pkg::SEC_BLU_MAG: begin
        r_lvl = data_i.t;   g_lvl = data_i.p;   b_lvl = bright_i;
      end
      default: begin
        r_lvl = bright_i;   g_lvl = data_i.p;   b_lvl = data_i.q;
      end
    endcase
    data_d.red   = to_chan(r_lvl);
    data_d.green = to_chan(g_lvl);
    data_d.blue  = to_chan(b_lvl);
    valid_d = en ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

  assign stall_o = !en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== sv/golden_hue_hsv_to_rgb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// golden_hue_hsv_to_rgb_top
// Golden-ratio hue step followed by HSV to 8-bit RGB conversion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / random_hue_i) takes one random
//   hue per transfer; output channel (out_valid_o / out_stall_i / red_o,
//   green_o, blue_o) delivers exactly one color per input, in order.
//   Configuration: cfg_we_i writes cfg_wdata_i into saturation (index 0) or
//   value (index 1); values above one saturate to one, other indexes are
//   dropped. Write only while no transfer is in flight.
//   Throughput: one item per cycle while out_stall_i is low, set by the
//   four-stage chain (sector split, saturation products, p/q/t products,
//   channel scaling).
//   Each stage holds while the one after it is full and stalled; a stall on
//   the output reaches in_stall_o only once the pipeline is full.
//   Reset: valid bits clear, saturation and value return to one.
// ----------------------------------------------------------------------------
`default_nettype none

module golden_hue_hsv_to_rgb_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ghh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ghh_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ghh_pkg::HUE_W-1:0]     random_hue_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ghh_pkg::CH_W-1:0]           red_o,
  output logic [ghh_pkg::CH_W-1:0]           green_o,
  output logic [ghh_pkg::CH_W-1:0]           blue_o
);

  ghh_pkg::level_t   sat, bright;
  logic              s1_valid, s1_stall;
  ghh_pkg::hue_t     s1_data;
  logic              s3_valid, s3_stall;
  ghh_pkg::lvl_set_t s3_data;
  ghh_pkg::rgb_t     rgb;

  ghh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sat_o       (sat),
    .bright_o    (bright)
  );

  ghh_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .hue_i   (random_hue_i),
    .valid_o (s1_valid),
    .stall_i (s1_stall),
    .data_o  (s1_data)
  );

  ghh_level u_level (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sat_i    (sat),
    .bright_i (bright),
    .valid_i  (s1_valid),
    .stall_o  (s1_stall),
    .data_i   (s1_data),
    .valid_o  (s3_valid),
    .stall_i  (s3_stall),
    .data_o   (s3_data)
  );

  ghh_color u_color (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bright_i (bright),
    .valid_i  (s3_valid),
    .stall_o  (s3_stall),
    .data_i   (s3_data),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .data_o   (rgb)
  );

  assign red_o   = rgb.red;
  assign green_o = rgb.green;
  assign blue_o  = rgb.blue;

endmodule

`default_nettype wire

// ===== sv/ghh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghh_checker
// Port-level checks of the color generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ghh_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [ghh_pkg::CH_W-1:0]    red_o,
  input wire logic [ghh_pkg::CH_W-1:0]    green_o,
  input wire logic [ghh_pkg::CH_W-1:0]    blue_o
);

  logic       in_xfer, out_xfer;
  logic [2:0] occ_q, occ_d;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // track items in flight
  always_comb begin
    occ_d = occ_q + 3'(in_xfer) - 3'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 3'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_no_stall_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_o)
      && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed or dropped");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'd4)
    else $error("more items in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != 3'd0)
    else $error("result without an accepted input");

endmodule

bind golden_hue_hsv_to_rgb_top ghh_checker u_ghh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for golden_hue_hsv_to_rgb_top. A queue-fed driver
// sends hues with random gaps, and a monitor applies random output stalls.
// Each accepted hue is run through a local fixed-point HSV predictor, and
// the monitor compares every color against it in order. Saturation and
// value are rewritten between drained phases: extremes, over-range values
// and random levels, plus writes to unused indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int          PIPE_LATENCY = 4;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          RAND_PHASES  = 8;
  localparam logic [63:0] UNITY        = 64'd1 << ghh_pkg::FRAC_BITS;
  localparam logic [63:0] PHI_Q32      = 64'd2654435769;
  localparam ghh_pkg::frac_t HUE_STEP  = ghh_pkg::frac_t'(
      (PHI_Q32 + (64'd1 << (31 - ghh_pkg::FRAC_BITS))) >> (32 - ghh_pkg::FRAC_BITS));

  // Indexes with no register behind them
  localparam logic [ghh_pkg::CFG_IDX_W-1:0] REG_SPARE_A = ghh_pkg::CFG_IDX_W'(2);
  localparam logic [ghh_pkg::CFG_IDX_W-1:0] REG_SPARE_B = ghh_pkg::CFG_IDX_W'(3);
  localparam logic [ghh_pkg::CFG_W-1:0]     CFG_MAX     = '1;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [ghh_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [ghh_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [ghh_pkg::HUE_W-1:0]     random_hue = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ghh_pkg::chan_t                red, green, blue;

  ghh_pkg::frac_t  hue_queue[$];
  ghh_pkg::rgb_t   color_queue[$];
  ghh_pkg::level_t sat_cfg    = ghh_pkg::level_t'(UNITY);
  ghh_pkg::level_t bright_cfg = ghh_pkg::level_t'(UNITY);
  int     in_idle_pct  = 10;
  int     out_idle_pct = 10;
  int     queued       = 0;
  int     accepted     = 0;
  int     checked      = 0;
  int     settings     = 0;
  int     errors       = 0;
  int     cycle_count  = 0;

  golden_hue_hsv_to_rgb_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .random_hue_i (random_hue),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  function automatic ghh_pkg::chan_t scale_255(logic [63:0] level);
    logic [63:0] c;
    c = (64'd255 * level) >> ghh_pkg::FRAC_BITS;
    return (c > 64'd255) ? ghh_pkg::chan_t'(255) : ghh_pkg::chan_t'(c);
  endfunction

  function automatic ghh_pkg::level_t clamp_level(logic [ghh_pkg::CFG_W-1:0] w);
    return (w > UNITY) ? ghh_pkg::level_t'(UNITY) : ghh_pkg::level_t'(w);
  endfunction

  // Golden-ratio step, then HSV to RGB with truncating fixed point
  function automatic ghh_pkg::rgb_t hsv_color(ghh_pkg::frac_t raw_hue,
                                              ghh_pkg::level_t sat,
                                              ghh_pkg::level_t val);
    ghh_pkg::frac_t           hue;
    logic [ghh_pkg::H6_W-1:0] h6;
    ghh_pkg::sector_t         sec;
    logic [63:0]              f, s, v, p, q, t, r, g, b;
    ghh_pkg::rgb_t            c;
    hue = raw_hue + HUE_STEP;
    h6  = ghh_pkg::H6_W'(hue) * ghh_pkg::H6_W'(6);
    sec = h6[ghh_pkg::H6_W-1:ghh_pkg::FRAC_BITS];
    f   = 64'(h6[ghh_pkg::FRAC_BITS-1:0]);
    s   = 64'(sat);
    v   = 64'(val);
    p   = (v * (UNITY - s)) >> ghh_pkg::FRAC_BITS;
    q   = (v * (UNITY - ((f * s) >> ghh_pkg::FRAC_BITS))) >> ghh_pkg::FRAC_BITS;
    t   = (v * (UNITY - (((UNITY - f) * s) >> ghh_pkg::FRAC_BITS))) >> ghh_pkg::FRAC_BITS;
    case (sec)
      ghh_pkg::SEC_RED_YEL: begin r = v; g = t; b = p; end
      ghh_pkg::SEC_YEL_GRN: begin r = q; g = v; b = p; end
      ghh_pkg::SEC_GRN_CYA: begin r = p; g = v; b = t; end
      ghh_pkg::SEC_CYA_BLU: begin r = p; g = q; b = v; end
      ghh_pkg::SEC_BLU_MAG: begin r = t; g = p; b = v; end
      default:              begin r = v; g = p; b = q; end
    endcase
    c.red   = scale_255(r);
    c.green = scale_255(g);
    c.blue  = scale_255(b);
    return c;
  endfunction

  // Raw input that lands on a given hue after the golden step
  function automatic ghh_pkg::frac_t raw_for(int target);
    return ghh_pkg::frac_t'(target) - HUE_STEP;
  endfunction

  // First hue of sector k
  function automatic int sector_start(int k);
    return (k * (1 << ghh_pkg::FRAC_BITS) + 5) / 6;
  endfunction

  function automatic ghh_pkg::frac_t pick_hue();
    if ($urandom_range(0, 9) < 7) begin
      return ghh_pkg::frac_t'($urandom_range(0, (1 << ghh_pkg::HUE_W) - 1));
    end
    return raw_for(sector_start($urandom_range(0, 5)) + $urandom_range(0, 6) - 3);
  endfunction

  function automatic logic [ghh_pkg::CFG_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ghh_pkg::CFG_W'(UNITY);
      2:       return ghh_pkg::CFG_W'($urandom_range(UNITY + 1, CFG_MAX));
      default: return ghh_pkg::CFG_W'($urandom_range(0, UNITY));
    endcase
  endfunction

  task automatic push_hue(ghh_pkg::frac_t h);
    hue_queue.push_back(h);
    queued++;
  endtask

  task automatic write_reg(logic [ghh_pkg::CFG_IDX_W-1:0] idx,
                           logic [ghh_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ghh_pkg::REG_SAT:    sat_cfg    = clamp_level(data);
      ghh_pkg::REG_BRIGHT: bright_cfg = clamp_level(data);
      default:             ;
    endcase
  endtask

  task automatic set_levels(logic [ghh_pkg::CFG_W-1:0] sat, logic [ghh_pkg::CFG_W-1:0] val);
    write_reg(ghh_pkg::REG_SAT, sat);
    write_reg(ghh_pkg::REG_BRIGHT, val);
    write_reg(REG_SPARE_A, ghh_pkg::CFG_W'($urandom()));
    write_reg(REG_SPARE_B, ghh_pkg::CFG_W'($urandom()));
    settings++;
  endtask

  // Hold until every hue is taken and every color has come back
  task automatic drain();
    while (accepted != queued || color_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic check_field(string name, ghh_pkg::chan_t want, ghh_pkg::chan_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d colors still pending", $time, color_queue.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Input driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      random_hue <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        color_queue.push_back(hsv_color(random_hue, sat_cfg, bright_cfg));
        accepted++;
      end
      // advance only when the current transfer is done or none is pending
      if (!in_valid || !in_stall) begin
        if (hue_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_valid   <= 1'b1;
          random_hue <= hue_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor
  always @(posedge clk or negedge rst_n) begin
    ghh_pkg::rgb_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (color_queue.size() == 0) begin
          $display("%0t: unexpected color, expected none, actual %0d/%0d/%0d",
                   $time, red, green, blue);
          errors++;
        end else begin
          want = color_queue.pop_front();
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset levels: raw extremes, wrap, and both sides of every sector edge
    push_hue('0);
    push_hue('1);
    push_hue(16'h5555);
    push_hue(16'hAAAA);
    push_hue(raw_for(0));
    push_hue(raw_for(1));
    push_hue(raw_for((1 << ghh_pkg::FRAC_BITS) - 1));
    for (int k = 1; k < 6; k++) begin
      push_hue(raw_for(sector_start(k) - 1));
      push_hue(raw_for(sector_start(k)));
    end
    drain();

    for (int ph = 0; ph < 5 + RAND_PHASES; ph++) begin
      case (ph)
        0:       set_levels('0, ghh_pkg::CFG_W'(UNITY));
        1:       set_levels(ghh_pkg::CFG_W'(UNITY), '0);
        2:       set_levels('0, '0);
        3:       set_levels(CFG_MAX, ghh_pkg::CFG_W'(UNITY + 1));
        4:       set_levels(ghh_pkg::CFG_W'(UNITY / 2), ghh_pkg::CFG_W'(3 * UNITY / 4));
        default: set_levels(pick_level(), pick_level());
      endcase
      // one long stretch with no gaps or stalls
      in_idle_pct  = (ph == 6) ? 0 : 10;
      out_idle_pct = (ph == 6) ? 0 : 10;
      for (int i = 0; i < PHASE_ITEMS; i++) push_hue(pick_hue());
      drain();
    end

    $display("tb: %0d hues sent, %0d colors checked over %0d level settings",
             accepted, checked, settings + 1);
    $display("tb: levels covered zero, one, over-range and random; unused indexes written");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
